// File: rtl/assert_macros.svh
// assertion macros shared by the decoder modules
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on every rising edge outside reset
`define QRD_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("assertion failed");

// condition that must never hold outside reset
`define QRD_ASSERT_NEVER(lbl, clk, rst_n, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error("forbidden condition seen");

`endif

// File: rtl/qrd_pkg.sv
// types and codes of the quadrature rotation decoder
`default_nettype none

package qrd_pkg;

  // phase of the quadrature cycle, code 7 unused
  typedef enum logic [2:0] {
    PH_IDLE        = 3'd0,
    PH_START_LEFT  = 3'd1,
    PH_ON_LEFT     = 3'd2,
    PH_END_LEFT    = 3'd3,
    PH_START_RIGHT = 3'd4,
    PH_ON_RIGHT    = 3'd5,
    PH_END_RIGHT   = 3'd6
  } phase_e;

  localparam logic DIR_LEFT  = 1'b0;
  localparam logic DIR_RIGHT = 1'b1;

  localparam int unsigned IdWidth = 8;

  // one sample of the sensor pins
  typedef struct packed {
    logic pin_left_raw;
    logic pin_right_raw;
  } qrd_in_t;

  // one rotation event
  typedef struct packed {
    logic [IdWidth-1:0] event_id;
    logic               turn_direction;
  } qrd_out_t;

  // decision of the phase logic for the item in the input register
  typedef struct packed {
    logic     emit;
    qrd_out_t item;
  } qrd_step_t;

endpackage

`default_nettype wire

// File: rtl/qrd_in_stage.sv
// input register of the decoder with its stall logic
`default_nettype none

module qrd_in_stage
  import qrd_pkg::*;
(
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  input  wire logic    in_valid_i,
  output      logic    in_stall_o,
  input  wire qrd_in_t in_item_i,
  input  wire logic    advance_i,
  output      logic    s1_valid_o,
  output      qrd_in_t s1_item_o
);

  logic    valid_q, valid_d;
  qrd_in_t item_q;
  logic    accept;

  // stall only while a held item cannot move on
  assign in_stall_o = valid_q && !advance_i;
  assign accept     = in_valid_i && !in_stall_o;

  // occupancy of the input register
  always_comb begin
    valid_d = valid_q;
    if (accept) begin
      valid_d = 1'b1;
    end else if (advance_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // sample payload
  always_ff @(posedge clk_i) begin
    if (accept) begin
      item_q <= in_item_i;
    end
  end

  assign s1_valid_o = valid_q;
  assign s1_item_o  = item_q;

endmodule

`default_nettype wire

// File: rtl/qrd_phase_fsm.sv
// phase state machine and level history of the decoder
`default_nettype none
`include "assert_macros.svh"

module qrd_phase_fsm
  import qrd_pkg::*;
(
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               take_i,
  input  wire qrd_in_t            item_i,
  input  wire logic [IdWidth-1:0] encoder_id_i,
  output      qrd_step_t          step_o
);

  phase_e state_q, state_d;
  logic   left_q, right_q;
  logic   lvl_l, lvl_r;
  logic   changed;

  // left pin is active low
  assign lvl_l   = !item_i.pin_left_raw;
  assign lvl_r   = item_i.pin_right_raw;
  assign changed = (lvl_l != left_q) || (lvl_r != right_q);

  // next phase and event decision
  always_comb begin
    state_d                    = state_q;
    step_o.emit                = 1'b0;
    step_o.item.event_id       = encoder_id_i;
    step_o.item.turn_direction = DIR_LEFT;
    if (changed) begin
      case (state_q)
        PH_START_LEFT: begin
          if (lvl_l && lvl_r) state_d = PH_ON_LEFT;
          else if (!lvl_l && !lvl_r) state_d = PH_IDLE;
        end
        PH_ON_LEFT: begin
          if (lvl_r && !lvl_l) state_d = PH_END_LEFT;
          else if (lvl_l && !lvl_r) state_d = PH_START_LEFT;
        end
        PH_END_LEFT: begin
          if (!lvl_l && !lvl_r) begin
            state_d     = PH_IDLE;
            step_o.emit = 1'b1;
          end else if (lvl_l && lvl_r) begin
            state_d = PH_ON_LEFT;
          end
        end
        PH_START_RIGHT: begin
          if (lvl_l && lvl_r) state_d = PH_ON_RIGHT;
          else if (!lvl_l && !lvl_r) state_d = PH_IDLE;
        end
        PH_ON_RIGHT: begin
          if (lvl_l && !lvl_r) state_d = PH_END_RIGHT;
          else if (!lvl_l && lvl_r) state_d = PH_START_RIGHT;
        end
        PH_END_RIGHT: begin
          if (!lvl_l && !lvl_r) begin
            state_d                    = PH_IDLE;
            step_o.emit                = 1'b1;
            step_o.item.turn_direction = DIR_RIGHT;
          end else if (lvl_l && lvl_r) begin
            state_d = PH_ON_RIGHT;
          end
        end
        // idle and the unused code
        default: begin
          if (lvl_l && !lvl_r) state_d = PH_START_LEFT;
          else if (lvl_r && !lvl_l) state_d = PH_START_RIGHT;
          else state_d = PH_IDLE;
        end
      endcase
    end
  end

  // state and previous levels, updated only when the item is taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= PH_IDLE;
      left_q  <= 1'b0;
      right_q <= 1'b0;
    end else if (take_i) begin
      state_q <= state_d;
      left_q  <= lvl_l;
      right_q <= lvl_r;
    end
  end

  // an event only leaves from an end phase
  `QRD_ASSERT(a_emit_from_end, clk_i, rst_ni,
              step_o.emit |-> (state_q == PH_END_LEFT || state_q == PH_END_RIGHT))
  // an item with unchanged levels leaves the phase alone
  `QRD_ASSERT(a_hold_unchanged, clk_i, rst_ni, (take_i && !changed) |=> $stable(state_q))
  // after an event the machine is idle
  `QRD_ASSERT(a_idle_after_emit, clk_i, rst_ni,
              (take_i && step_o.emit) |=> (state_q == PH_IDLE))

endmodule

`default_nettype wire

// File: rtl/qrd_out_stage.sv
// result register of the decoder
`default_nettype none
`include "assert_macros.svh"

module qrd_out_stage
  import qrd_pkg::*;
(
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      s1_valid_i,
  input  wire qrd_step_t step_i,
  output      logic      advance_o,
  output      logic      out_valid_o,
  input  wire logic      out_stall_i,
  output      qrd_out_t  out_item_o
);

  logic     valid_q, valid_d;
  qrd_out_t item_q;
  logic     load;

  // register free or being emptied this cycle
  assign advance_o = !valid_q || !out_stall_i;
  assign load      = advance_o && s1_valid_i && step_i.emit;

  always_comb begin
    valid_d = valid_q;
    if (advance_o) begin
      valid_d = s1_valid_i && step_i.emit;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // event payload
  always_ff @(posedge clk_i) begin
    if (load) begin
      item_q <= step_i.item;
    end
  end

  assign out_valid_o = valid_q;
  assign out_item_o  = item_q;

  // a new item appears only after a load
  `QRD_ASSERT(a_rise_from_load, clk_i, rst_ni, $rose(valid_q) |-> $past(load))

endmodule

`default_nettype wire

// File: rtl/quadrature_rotation_decoder_unit.sv
// Quadrature rotation decoder, top level.
// A rotation event passes the input register and then the result register.
// Throughput: one sample per cycle unless a full result register is stalled.
// The phase update is one case decision between the two registers.
// Reset (asynchronous, active low): phase idle, stored levels zero,
// encoder id zero, both registers empty.
`default_nettype none

module quadrature_rotation_decoder_unit
  import qrd_pkg::*;
(
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               cfg_we_i,
  input  wire logic [IdWidth-1:0] cfg_wdata_i,
  input  wire logic               in_valid_i,
  output      logic               in_stall_o,
  input  wire qrd_in_t            in_item_i,
  output      logic               out_valid_o,
  input  wire logic               out_stall_i,
  output      qrd_out_t           out_item_o
);

  logic [IdWidth-1:0] encoder_id_q;
  logic               advance;
  logic               s1_valid;
  qrd_in_t            s1_item;
  qrd_step_t          step;

  // encoder id register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      encoder_id_q <= '0;
    end else if (cfg_we_i) begin
      encoder_id_q <= cfg_wdata_i;
    end
  end

  // input register
  qrd_in_stage u_in_stage (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_item_i  (in_item_i),
    .advance_i  (advance),
    .s1_valid_o (s1_valid),
    .s1_item_o  (s1_item)
  );

  // phase logic
  qrd_phase_fsm u_phase_fsm (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .take_i       (s1_valid && advance),
    .item_i       (s1_item),
    .encoder_id_i (encoder_id_q),
    .step_o       (step)
  );

  // result register
  qrd_out_stage u_out_stage (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .s1_valid_i  (s1_valid),
    .step_i      (step),
    .advance_o   (advance),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_item_o  (out_item_o)
  );

endmodule

`default_nettype wire

// File: tb/sv/rotation_event_checker.sv
// checker that predicts and compares the rotation events of the decoder
`default_nettype none

module rotation_event_checker
  import qrd_pkg::*;
(
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               cfg_we_i,
  input  wire logic [IdWidth-1:0] cfg_wdata_i,
  input  wire logic               in_valid_i,
  input  wire logic               in_stall_i,
  input  wire qrd_in_t            in_item_i,
  input  wire logic               out_valid_i,
  input  wire logic               out_stall_i,
  input  wire qrd_out_t           out_item_i,
  output int                      fail_count_o,
  output int                      pending_o
);

  // predicted decoder state
  phase_e             phase_q;
  logic               left_q;
  logic               right_q;
  logic [IdWidth-1:0] encoder_id_q;
  qrd_out_t           rotations_due[$];
  int                 fails = 0;

  assign fail_count_o = fails;

  // one sample through the phase machine, returns 1 when a rotation completes
  function automatic bit advance_phase(input qrd_in_t s, output qrd_out_t ev);
    logic l;
    logic r;
    bit   moved;
    bit   emit;
    l = ~s.pin_left_raw;
    r = s.pin_right_raw;
    moved = (l != left_q) || (r != right_q);
    left_q = l;
    right_q = r;
    emit = 1'b0;
    ev = '0;
    if (!moved) return 1'b0;
    case (phase_q)
      PH_START_LEFT: begin
        if (l && r) phase_q = PH_ON_LEFT;
        else if (!l && !r) phase_q = PH_IDLE;
      end
      PH_ON_LEFT: begin
        if (r && !l) phase_q = PH_END_LEFT;
        else if (l && !r) phase_q = PH_START_LEFT;
      end
      PH_END_LEFT: begin
        if (!l && !r) begin
          phase_q = PH_IDLE;
          emit = 1'b1;
          ev.turn_direction = DIR_LEFT;
        end else if (l && r) begin
          phase_q = PH_ON_LEFT;
        end
      end
      PH_START_RIGHT: begin
        if (l && r) phase_q = PH_ON_RIGHT;
        else if (!l && !r) phase_q = PH_IDLE;
      end
      PH_ON_RIGHT: begin
        if (l && !r) phase_q = PH_END_RIGHT;
        else if (!l && r) phase_q = PH_START_RIGHT;
      end
      PH_END_RIGHT: begin
        if (!l && !r) begin
          phase_q = PH_IDLE;
          emit = 1'b1;
          ev.turn_direction = DIR_RIGHT;
        end else if (l && r) begin
          phase_q = PH_ON_RIGHT;
        end
      end
      default: begin
        if (l && !r) phase_q = PH_START_LEFT;
        else if (r && !l) phase_q = PH_START_RIGHT;
        else phase_q = PH_IDLE;
      end
    endcase
    ev.event_id = encoder_id_q;
    return emit;
  endfunction

  // watch both channels and the register port
  always @(posedge clk_i or negedge rst_ni) begin
    qrd_out_t due;
    qrd_out_t ev;
    if (!rst_ni) begin
      phase_q = PH_IDLE;
      left_q = 1'b0;
      right_q = 1'b0;
      encoder_id_q = '0;
      rotations_due.delete();
      pending_o <= 0;
    end else begin
      if (cfg_we_i) encoder_id_q = cfg_wdata_i;
      // result item first, it cannot stem from a sample taken at this edge
      if (out_valid_i && !out_stall_i) begin
        if (rotations_due.size() == 0) begin
          $error("unexpected rotation item: event_id %0d turn_direction %0d",
                 out_item_i.event_id, out_item_i.turn_direction);
          fails++;
        end else begin
          due = rotations_due.pop_front();
          if (out_item_i.event_id !== due.event_id) begin
            $error("event_id: expected %0d, actual %0d", due.event_id, out_item_i.event_id);
            fails++;
          end
          if (out_item_i.turn_direction !== due.turn_direction) begin
            $error("turn_direction: expected %0d, actual %0d",
                   due.turn_direction, out_item_i.turn_direction);
            fails++;
          end
        end
      end
      // sample item
      if (in_valid_i && !in_stall_i) begin
        if (advance_phase(in_item_i, ev)) rotations_due.push_back(ev);
      end
      pending_o <= rotations_due.size();
    end
  end

endmodule

`default_nettype wire

// File: tb/sv/quadrature_rotation_decoder_unit_tb.sv
// stimulus and verdict for the quadrature rotation decoder
`default_nettype none

module quadrature_rotation_decoder_unit_tb;
  import qrd_pkg::*;

  localparam int CycleLimit = 400000;
  localparam int SettleCycles = 4;
  localparam int ItemsPerPhase = 330;

  logic               clk_i;
  logic               rst_ni;
  logic               cfg_we_i;
  logic [IdWidth-1:0] cfg_wdata_i;
  logic               in_valid_i;
  logic               in_stall_o;
  qrd_in_t            in_item_i;
  logic               out_valid_o;
  logic               out_stall_i;
  qrd_out_t           out_item_o;
  int                 fail_count;
  int                 pending;
  int                 gap_pct = 0;
  int                 stall_pct = 0;
  int                 cycles = 0;

  quadrature_rotation_decoder_unit dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_item_i  (in_item_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_item_o (out_item_o)
  );

  rotation_event_checker checker_i (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (in_valid_i),
    .in_stall_i  (in_stall_o),
    .in_item_i   (in_item_i),
    .out_valid_i (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_item_i  (out_item_o),
    .fail_count_o(fail_count),
    .pending_o   (pending)
  );

  // clock
  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // receiver back-pressure
  always @(negedge clk_i) begin
    out_stall_i <= (stall_pct > 0) && ($urandom_range(99) < stall_pct);
  end

  // watchdog
  initial begin
    while (cycles < CycleLimit) begin
      @(posedge clk_i);
      cycles++;
    end
    $display("Verification failed");
    $finish;
  end

  // sample from decoded levels, left pin is active low
  function automatic qrd_in_t levels(input bit l, input bit r);
    qrd_in_t s;
    s.pin_left_raw = ~l;
    s.pin_right_raw = r;
    return s;
  endfunction

  // offer one sample and hold it until taken
  task automatic send_sample(input qrd_in_t s);
    while ($urandom_range(99) < gap_pct) begin
      @(negedge clk_i);
      in_valid_i <= 1'b0;
    end
    @(negedge clk_i);
    in_valid_i <= 1'b1;
    in_item_i <= s;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
  endtask

  // stop sending and wait until every rotation has come out
  task automatic settle();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  // register write while the decoder is idle
  task automatic write_encoder_id(input logic [IdWidth-1:0] id);
    @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= id;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // random walk over the gray sequence, mostly whole cycles with some noise
  task automatic walk_samples(input int count);
    bit [1:0] gray[4];
    int       pos;
    bit       fwd;
    int       pick;
    gray = '{2'b00, 2'b10, 2'b11, 2'b01};
    pos = 0;
    fwd = 1'($urandom_range(1));
    for (int i = 0; i < count; i++) begin
      pick = $urandom_range(99);
      if (pick < 10) begin
        // repeat the current levels
      end else if (pick < 17) begin
        pos = $urandom_range(3);
      end else if (pick < 27) begin
        pos = fwd ? (pos + 3) % 4 : (pos + 1) % 4;
      end else begin
        pos = fwd ? (pos + 1) % 4 : (pos + 3) % 4;
      end
      if (pos == 0 && $urandom_range(1)) fwd = ~fwd;
      send_sample(levels(gray[pos][1], gray[pos][0]));
      // sender holds off until the decoder has drained
      if (i == count / 2) settle();
    end
  endtask

  // main sequence
  initial begin
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_wdata_i = '0;
    in_valid_i = 1'b0;
    in_item_i = '0;
    out_stall_i = 1'b0;
    repeat (10) @(negedge clk_i);
    rst_ni <= 1'b1;

    // full left turn with the id at its reset value
    send_sample(levels(1, 0));
    send_sample(levels(1, 1));
    send_sample(levels(0, 1));
    send_sample(levels(0, 0));
    settle();
    write_encoder_id(8'hFF);
    // full right turn with repeated levels, then a jump to both on from idle
    send_sample(levels(0, 1));
    send_sample(levels(0, 1));
    send_sample(levels(1, 1));
    send_sample(levels(1, 0));
    send_sample(levels(0, 0));
    send_sample(levels(1, 1));
    send_sample(levels(0, 0));
    // left with aborted start, reversals and an off-sequence level
    send_sample(levels(1, 0));
    send_sample(levels(0, 1));
    send_sample(levels(0, 0));
    send_sample(levels(1, 0));
    send_sample(levels(1, 1));
    send_sample(levels(1, 0));
    send_sample(levels(1, 1));
    send_sample(levels(0, 1));
    send_sample(levels(1, 1));
    send_sample(levels(0, 1));
    send_sample(levels(0, 0));
    // right with reversals
    send_sample(levels(0, 1));
    send_sample(levels(1, 1));
    send_sample(levels(0, 1));
    send_sample(levels(1, 1));
    send_sample(levels(1, 0));
    send_sample(levels(1, 1));
    send_sample(levels(1, 0));
    send_sample(levels(0, 0));
    settle();

    // sender mostly busy, receiver often stalled
    write_encoder_id(8'h00);
    gap_pct = 6;
    stall_pct = 71;
    walk_samples(ItemsPerPhase);
    settle();

    // sender often idle, receiver mostly ready
    write_encoder_id(8'($urandom_range(255)));
    gap_pct = 71;
    stall_pct = 6;
    walk_samples(ItemsPerPhase);
    settle();

    // no idling on either side
    write_encoder_id(8'($urandom_range(255)));
    gap_pct = 0;
    stall_pct = 0;
    walk_samples(ItemsPerPhase);
    settle();

    if (fail_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

`default_nettype wire
